### hw/rtl/acs_pkg.sv
// Shared constants and types for the alignment column statistics block.
// No dependencies; used by every module under hw/rtl.
package acs_pkg;

    localparam int CFG_W       = 16;  // min_matches register width
    localparam int OUT_W       = 32;  // width of each reported total
    localparam int NUM_TOT     = 8;   // number of running totals
    localparam int QUEUE_DEPTH = 2;   // block records between front and back

    localparam logic [CFG_W-1:0] MIN_MATCHES_RESET = 16'd50;

    // Alignment symbols (ASCII)
    localparam logic [7:0] SYM_GAP  = 8'h2D;  // '-'
    localparam logic [7:0] SYM_A_LO = 8'h61;  // 'a'
    localparam logic [7:0] SYM_T_LO = 8'h74;  // 't'
    localparam logic [7:0] SYM_A_UP = 8'h41;  // 'A'
    localparam logic [7:0] SYM_T_UP = 8'h54;  // 'T'

    // Total slots, in output order
    localparam int TOT_MATCH    = 0;
    localparam int TOT_MISMATCH = 1;
    localparam int TOT_AT       = 2;
    localparam int TOT_OPENS    = 3;
    localparam int TOT_GAPS     = 4;
    localparam int TOT_BLOCKS   = 5;
    localparam int TOT_SPAN     = 6;
    localparam int TOT_FILES    = 7;

    // Queue status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

### hw/rtl/alignment_column_stats.sv
// Alignment column statistics: a block's record passes through the record queue into the result register.
// Throughput one column per cycle while the record queue is not full, also with one-column
// blocks; the front counters and the combinational saturating adders in the back end set that figure.
// A result waits in the output register while the 2-entry record queue keeps the front going.
// Reset is synchronous, active low: counters, totals, queue and result valid clear,
// min_matches returns to 50.
module alignment_column_stats #(
    parameter int BLOCK_COUNT_BITS = 16,
    parameter int TOTAL_BITS       = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // column stream in
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [47:0]                        i_s_tdata,  // q_sym, t_sym, query_span
    input  logic                               i_s_tlast,  // last_in_block
    input  logic                               i_s_tuser,  // last_in_file
    // block result stream out
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // match_total, mismatch_total, at_match_total, insert_count_total,
    // inserted_base_total, kept_block_total, span_total, file_hit_total
    output logic [255:0]                       o_m_tdata,
    output logic                               o_m_tuser,  // block_kept
    // min_matches write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [acs_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int BCB   = BLOCK_COUNT_BITS;
    // block record: file_end, span, gaps, opens, at, mismatches, matches (high to low)
    localparam int REC_W = 5 * BCB + 33;

    acs_pkg::t_q_status q_status;

    logic             push, pop, file_end_f;
    logic [BCB-1:0]   f_matches, f_mismatches, f_at, f_opens, f_gaps;
    logic [31:0]      f_span;
    logic [REC_W-1:0] wr_rec, rd_rec;

    // Front end: classification and per-block counting, one column a cycle while the queue is not full
    acs_front #(
        .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_q_sym      (i_s_tdata[7:0]),
        .i_t_sym      (i_s_tdata[15:8]),
        .i_last_blk   (i_s_tlast),
        .i_last_file  (i_s_tuser),
        .i_span       (i_s_tdata[47:16]),
        .i_q          (q_status),
        .o_push       (push),
        .o_matches    (f_matches),
        .o_mismatches (f_mismatches),
        .o_at_matches (f_at),
        .o_opens      (f_opens),
        .o_gaps       (f_gaps),
        .o_span       (f_span),
        .o_file_end   (file_end_f)
    );

    assign wr_rec = {file_end_f, f_span, f_gaps, f_opens, f_at, f_mismatches, f_matches};

    // Record queue: lets the back end stall on the result side independently
    acs_fifo #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_rec),
        .i_pop     (pop),
        .o_rd_data (rd_rec),
        .o_status  (q_status)
    );

    // Back end: threshold, saturating totals, file hit tracking, result register
    acs_back #(
        .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS),
        .TOTAL_BITS       (TOTAL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q          (q_status),
        .o_pop        (pop),
        .i_matches    (rd_rec[0*BCB +: BCB]),
        .i_mismatches (rd_rec[1*BCB +: BCB]),
        .i_at_matches (rd_rec[2*BCB +: BCB]),
        .i_opens      (rd_rec[3*BCB +: BCB]),
        .i_gaps       (rd_rec[4*BCB +: BCB]),
        .i_span       (rd_rec[5*BCB +: 32]),
        .i_file_end   (rd_rec[REC_W-1]),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kept       (o_m_tuser),
        .o_totals     (o_m_tdata)
    );

endmodule

### hw/rtl/acs_front.sv
// Front end: classifies each alignment column and keeps the per-block counters.
// Depends on acs_pkg; emits one block record per block end into the queue.
module acs_front #(
    parameter int BLOCK_COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_q_sym,
    input  logic [7:0]                  i_t_sym,
    input  logic                        i_last_blk,
    input  logic                        i_last_file,
    input  logic [31:0]                 i_span,
    input  acs_pkg::t_q_status          i_q,
    output logic                        o_push,
    output logic [BLOCK_COUNT_BITS-1:0] o_matches,
    output logic [BLOCK_COUNT_BITS-1:0] o_mismatches,
    output logic [BLOCK_COUNT_BITS-1:0] o_at_matches,
    output logic [BLOCK_COUNT_BITS-1:0] o_opens,
    output logic [BLOCK_COUNT_BITS-1:0] o_gaps,
    output logic [31:0]                 o_span,
    output logic                        o_file_end
);

    localparam int BCB = BLOCK_COUNT_BITS;

    logic [BCB-1:0] r_matches, r_mismatches, r_at, r_opens, r_gaps;
    logic [BCB-1:0] n_matches, n_mismatches, n_at, n_opens, n_gaps;
    logic           r_start, r_prev_q_gap, r_prev_t_gap;
    logic           q_gap, t_gap, is_match, is_at, is_open, is_gap_col, is_mism;
    logic           accept;

    function automatic logic [BCB-1:0] sat_inc(input logic [BCB-1:0] v, input logic en);
        sat_inc = (en && (v != {BCB{1'b1}})) ? v + 1'b1 : v;
    endfunction

    always_comb begin
        q_gap      = (i_q_sym == acs_pkg::SYM_GAP);
        t_gap      = (i_t_sym == acs_pkg::SYM_GAP);
        is_match   = (i_q_sym == i_t_sym);
        is_at      = is_match && ((i_q_sym == acs_pkg::SYM_A_LO) ||
                                  (i_q_sym == acs_pkg::SYM_T_LO) ||
                                  (i_q_sym == acs_pkg::SYM_A_UP) ||
                                  (i_q_sym == acs_pkg::SYM_T_UP));
        is_gap_col = !is_match && (q_gap || t_gap);
        // query gap takes precedence when checking for an opened insert
        if (q_gap) begin
            is_open = is_gap_col && !r_start && !r_prev_q_gap;
        end else begin
            is_open = is_gap_col && !r_start && !r_prev_t_gap;
        end
        is_mism = !is_match && !is_gap_col;

        n_matches    = sat_inc(r_matches, is_match);
        n_at         = sat_inc(r_at, is_at);
        n_gaps       = sat_inc(r_gaps, is_gap_col);
        n_opens      = sat_inc(r_opens, is_open);
        n_mismatches = sat_inc(r_mismatches, is_mism);
    end

    assign o_ready      = !i_q.full;
    assign accept       = i_valid && o_ready;
    assign o_push       = accept && i_last_blk;
    assign o_matches    = n_matches;
    assign o_mismatches = n_mismatches;
    assign o_at_matches = n_at;
    assign o_opens      = n_opens;
    assign o_gaps       = n_gaps;
    assign o_span       = i_span;
    assign o_file_end   = i_last_file;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matches    <= '0;
            r_mismatches <= '0;
            r_at         <= '0;
            r_opens      <= '0;
            r_gaps       <= '0;
            r_start      <= 1'b1;
            r_prev_q_gap <= 1'b0;
            r_prev_t_gap <= 1'b0;
        end else if (accept) begin
            if (i_last_blk) begin
                r_matches    <= '0;
                r_mismatches <= '0;
                r_at         <= '0;
                r_opens      <= '0;
                r_gaps       <= '0;
                r_start      <= 1'b1;
                r_prev_q_gap <= 1'b0;
                r_prev_t_gap <= 1'b0;
            end else begin
                r_matches    <= n_matches;
                r_mismatches <= n_mismatches;
                r_at         <= n_at;
                r_opens      <= n_opens;
                r_gaps       <= n_gaps;
                r_start      <= 1'b0;
                r_prev_q_gap <= q_gap;
                r_prev_t_gap <= t_gap;
            end
        end
    end

endmodule

### hw/rtl/acs_fifo.sv
// Short queue of block records between front and back end.
// Depends on acs_pkg for depth and status type.
module acs_fifo #(
    parameter int WIDTH = 114
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_wr_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_rd_data,
    output acs_pkg::t_q_status o_status
);

    localparam int DEPTH = acs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CNT_W'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    assign o_rd_data          = r_mem[r_rd];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == CNT_W'(DEPTH));

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_W'(DEPTH))))
        else $error("block record pushed into full queue");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy out of range");
`endif

endmodule

### hw/rtl/acs_back.sv
// Back end: min_matches check, saturating totals and the result register.
// Depends on acs_pkg; consumes block records from acs_fifo.
module acs_back #(
    parameter int BLOCK_COUNT_BITS = 16,
    parameter int TOTAL_BITS       = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [acs_pkg::CFG_W-1:0]               i_cfg_data,
    input  acs_pkg::t_q_status                      i_q,
    output logic                                    o_pop,
    input  logic [BLOCK_COUNT_BITS-1:0]             i_matches,
    input  logic [BLOCK_COUNT_BITS-1:0]             i_mismatches,
    input  logic [BLOCK_COUNT_BITS-1:0]             i_at_matches,
    input  logic [BLOCK_COUNT_BITS-1:0]             i_opens,
    input  logic [BLOCK_COUNT_BITS-1:0]             i_gaps,
    input  logic [31:0]                             i_span,
    input  logic                                    i_file_end,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_kept,
    output logic [acs_pkg::NUM_TOT*acs_pkg::OUT_W-1:0] o_totals
);

    localparam int BCB   = BLOCK_COUNT_BITS;
    localparam int TB    = TOTAL_BITS;
    localparam int NT    = acs_pkg::NUM_TOT;
    localparam int OW    = acs_pkg::OUT_W;
    localparam int CW    = acs_pkg::CFG_W;
    localparam int CMP_W = (BCB > CW) ? BCB : CW;
    localparam int MX1   = (TB > BCB) ? TB : BCB;
    localparam int MX2   = (MX1 > OW) ? MX1 : OW;
    localparam int W     = MX2 + 1;   // room for the carry of every add

    localparam logic [W-1:0] TOT_MAX_W = {{(W-TB){1'b0}}, {TB{1'b1}}};
    localparam logic [W-1:0] OUT_MAX_W = {{(W-OW){1'b0}}, {OW{1'b1}}};

    logic [CW-1:0]    r_min_matches;
    logic [TB-1:0]    r_tot [NT];
    logic [TB-1:0]    n_tot [NT];
    logic             r_file_hit, n_file_hit;
    logic             r_out_valid, r_out_kept;
    logic [NT*OW-1:0] r_out_data, n_out_data;
    logic [W-1:0]     addend [NT];
    logic [NT-1:0]    add_en;
    logic [W-1:0]     sum, ext;
    logic             kept, pop;

    assign o_cfg_ready = 1'b1;
    assign pop         = i_q.not_empty && (!r_out_valid || i_ready);
    assign o_pop       = pop;
    assign kept        = CMP_W'(i_matches) >= CMP_W'(r_min_matches);

    always_comb begin
        addend[acs_pkg::TOT_MATCH]    = W'(i_matches);
        addend[acs_pkg::TOT_MISMATCH] = W'(i_mismatches);
        addend[acs_pkg::TOT_AT]       = W'(i_at_matches);
        addend[acs_pkg::TOT_OPENS]    = W'(i_opens);
        addend[acs_pkg::TOT_GAPS]     = W'(i_gaps);
        addend[acs_pkg::TOT_BLOCKS]   = W'(1'b1);
        addend[acs_pkg::TOT_SPAN]     = W'(i_span);
        addend[acs_pkg::TOT_FILES]    = W'(1'b1);

        add_en                     = {NT{kept}};
        add_en[acs_pkg::TOT_FILES] = i_file_end && (r_file_hit || kept);
        n_file_hit                 = i_file_end ? 1'b0 : (r_file_hit || kept);

        n_out_data = '0;
        sum        = '0;
        ext        = '0;
        for (int i = 0; i < NT; i++) begin
            sum = W'(r_tot[i]) + addend[i];
            if (!add_en[i]) begin
                n_tot[i] = r_tot[i];
            end else if (sum > TOT_MAX_W) begin
                n_tot[i] = {TB{1'b1}};
            end else begin
                n_tot[i] = sum[TB-1:0];
            end
            // report clamped to the output width
            ext = W'(n_tot[i]);
            n_out_data[i*OW +: OW] = (ext > OUT_MAX_W) ? {OW{1'b1}} : ext[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_matches <= acs_pkg::MIN_MATCHES_RESET;
            r_file_hit    <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                r_tot[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_min_matches <= i_cfg_data;
            end
            if (pop) begin
                r_file_hit  <= n_file_hit;
                r_out_valid <= 1'b1;
                for (int i = 0; i < NT; i++) begin
                    r_tot[i] <= n_tot[i];
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_kept <= kept;
            r_out_data <= n_out_data;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_kept   = r_out_kept;
    assign o_totals = r_out_data;

`ifndef SYNTH
    a_dropped_block_leaves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !kept) |=> $stable(r_tot[acs_pkg::TOT_BLOCKS]))
        else $error("kept block count moved on a dropped block");

    a_totals_never_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_tot[acs_pkg::TOT_MATCH] >= $past(r_tot[acs_pkg::TOT_MATCH])))
        else $error("match total decreased");

    a_no_pop_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !pop)
        else $error("result overwritten before it was taken");
`endif

endmodule
